/* sv/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define MGD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never hold
`define MGD_NEVER(lbl, clk, rst_n, cond, msg) \
	`MGD_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define MGD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MGD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* sv/mgd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgd_pkg
// types, codes and constants of the masked grid diffusion block
// ----------------------------------------------------------------------------
package mgd_pkg;

	localparam int DEF_MAX_COLS = 256;
	localparam int DEF_MAX_ROWS = 256;

	localparam int P_W    = 18;
	localparam int GAIN_W = 16;
	localparam int LAP_W  = 21;
	localparam int PROD_W = 38;
	localparam int NV_W   = 23;
	localparam int DIM_W  = 11;

	localparam logic signed [P_W-1:0] ONE_Q12 = 18'sd4096;
	localparam logic signed [NV_W-1:0] P_MAX = 23'sd131071;
	localparam logic signed [NV_W-1:0] P_MIN = -23'sd131072;

	localparam logic [8:0]  RST_COLS = 9'd240;
	localparam logic [8:0]  RST_ROWS = 9'd160;
	localparam logic [15:0] RST_GAIN = 16'd13107;

	// register indexes of the config port
	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_GAIN = 2'd2;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_SWEEP = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		RSP_ZERO,
		RSP_RANGE,
		RSP_READ,
		RSP_SWEEP
	} rsp_src_t;

	typedef struct packed {
		logic                  wall;
		logic signed [P_W-1:0] pressure;
	} cell_t;

	typedef struct packed {
		logic     load_we;
		logic     sweep_start;
		logic     sweep_issue;
		logic     rsp_ld;
		rsp_src_t rsp_src;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_range;
		logic small_grid;
		logic issue_last;
		logic pipe_busy;
	} ctl_status_t;

endpackage

/* sv/mgd_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgd interfaces
// request, response and config channels with valid / ready
// ----------------------------------------------------------------------------
interface mgd_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [7:0]        col;
	logic [7:0]        row;
	logic signed [17:0] pressure_in;
	logic              wall_in;
	modport source (output valid, action, col, row, pressure_in, wall_in, input ready);
	modport sink (input valid, action, col, row, pressure_in, wall_in, output ready);
endinterface

interface mgd_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [17:0] pressure_out;
	logic              wall_out;
	logic              status;
	logic              saturated;
	modport source (output valid, pressure_out, wall_out, status, saturated, input ready);
	modport sink (input valid, pressure_out, wall_out, status, saturated, output ready);
endinterface

interface mgd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/mgd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgd_ctrl
// sequencer for load, read and sweep requests and the response slot
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mgd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic [1:0]           req_action,
	output logic                 req_ready,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	input  mgd_pkg::ctl_status_t sts,
	output mgd_pkg::ctl_cmd_t    cmd
);

	mgd_pkg::state_t state_q, state_nx;
	logic rsp_valid_q;
	logic req_fire;

	assign req_ready = (state_q == mgd_pkg::ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mgd_pkg::ST_IDLE: begin
				if (req_fire) begin
					priority case (req_action)
						mgd_pkg::ACT_READ:  if (sts.in_range) state_nx = mgd_pkg::ST_READ;
						mgd_pkg::ACT_SWEEP: if (!sts.small_grid) state_nx = mgd_pkg::ST_SWEEP;
						default:            state_nx = mgd_pkg::ST_IDLE;
					endcase
				end
			end
			mgd_pkg::ST_READ:  state_nx = mgd_pkg::ST_IDLE;
			mgd_pkg::ST_SWEEP: if (sts.issue_last) state_nx = mgd_pkg::ST_DRAIN;
			mgd_pkg::ST_DRAIN: if (!sts.pipe_busy) state_nx = mgd_pkg::ST_IDLE;
			default:           state_nx = mgd_pkg::ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd = '0;
		cmd.rsp_src = mgd_pkg::RSP_ZERO;
		unique case (state_q)
			mgd_pkg::ST_IDLE: begin
				if (req_fire) begin
					priority case (req_action)
						mgd_pkg::ACT_LOAD: begin
							cmd.load_we = sts.in_range;
							cmd.rsp_ld  = 1'b1;
							cmd.rsp_src = sts.in_range ? mgd_pkg::RSP_ZERO : mgd_pkg::RSP_RANGE;
						end
						mgd_pkg::ACT_READ: begin
							cmd.rsp_ld  = !sts.in_range;
							cmd.rsp_src = mgd_pkg::RSP_RANGE;
						end
						mgd_pkg::ACT_SWEEP: begin
							cmd.sweep_start = 1'b1;
							cmd.rsp_ld      = sts.small_grid;
						end
						default: cmd.rsp_ld = 1'b1;
					endcase
				end
			end
			mgd_pkg::ST_READ: begin
				cmd.rsp_ld  = 1'b1;
				cmd.rsp_src = mgd_pkg::RSP_READ;
			end
			mgd_pkg::ST_SWEEP: cmd.sweep_issue = 1'b1;
			mgd_pkg::ST_DRAIN: begin
				cmd.rsp_ld  = !sts.pipe_busy;
				cmd.rsp_src = mgd_pkg::RSP_SWEEP;
			end
			default: cmd = '0;
		endcase
	end

	// state and response slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mgd_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.rsp_ld) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	`MGD_NEVER(a_ld_full, clk, arst_n, cmd.rsp_ld && rsp_valid_q && !rsp_ready, "response slot overrun")
	`MGD_ASSERT(a_drain_after_sweep, clk, arst_n, (state_q == mgd_pkg::ST_DRAIN) |-> ($past(state_q) == mgd_pkg::ST_SWEEP || $past(state_q) == mgd_pkg::ST_DRAIN), "drain not entered from sweep")
	`MGD_ASSERT(a_read_resp, clk, arst_n, (state_q == mgd_pkg::ST_READ) |=> rsp_valid_q, "read gave no response")

endmodule

/* sv/mgd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgd_datapath
// cell memory, line buffers, stencil pipeline, config and response registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mgd_datapath #(
	parameter int MAX_COLS = mgd_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = mgd_pkg::DEF_MAX_ROWS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic [7:0]             req_col,
	input  logic [7:0]             req_row,
	input  logic signed [17:0]     req_pressure,
	input  logic                   req_wall,
	input  mgd_pkg::ctl_cmd_t      cmd,
	output mgd_pkg::ctl_status_t   sts,
	output logic signed [17:0]     pressure_out,
	output logic                   wall_out,
	output logic                   status,
	output logic                   saturated
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int AW  = CW + RW;
	localparam int DCW = $clog2(MAX_COLS + 1);
	localparam int DRW = $clog2(MAX_ROWS + 1);
	localparam int DW  = mgd_pkg::DIM_W;

	// config registers
	logic [8:0]  cols_q, rows_q;
	logic [15:0] gain_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= mgd_pkg::RST_COLS;
			rows_q <= mgd_pkg::RST_ROWS;
			gain_q <= mgd_pkg::RST_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mgd_pkg::REG_COLS: cols_q <= cfg_data[8:0];
				mgd_pkg::REG_ROWS: rows_q <= cfg_data[8:0];
				mgd_pkg::REG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// grid size clamped to the storage
	logic [DW-1:0] cols_x, rows_x;
	logic [DCW-1:0] eff_w;
	logic [DRW-1:0] eff_h;
	always_comb begin
		cols_x = (DW'(cols_q) > DW'(MAX_COLS)) ? DW'(MAX_COLS) : DW'(cols_q);
		rows_x = (DW'(rows_q) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(rows_q);
		eff_w  = cols_x[DCW-1:0];
		eff_h  = rows_x[DRW-1:0];
	end

	logic [CW-1:0] cc_q, cc_s1, col_s2, col_s3, col_s4, col_s5;
	logic [RW-1:0] rr_q, rr_s1, row_s2, row_s3, row_s4, row_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic col_last, row_last;

	assign col_last = (DW'(cc_q) == DW'(eff_w) - DW'(1));
	assign row_last = (DW'(rr_q) == DW'(eff_h) - DW'(1));

	always_comb begin
		sts.in_range   = (DW'(req_col) < DW'(eff_w)) && (DW'(req_row) < DW'(eff_h));
		sts.small_grid = (DW'(eff_w) < DW'(3)) || (DW'(eff_h) < DW'(3));
		sts.issue_last = col_last && row_last;
		sts.pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	end

	// raster counters of the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= '0;
			rr_q <= '0;
		end else if (cmd.sweep_start) begin
			cc_q <= '0;
			rr_q <= '0;
		end else if (cmd.sweep_issue) begin
			if (col_last) begin
				cc_q <= '0;
				rr_q <= rr_q + RW'(1);
			end else begin
				cc_q <= cc_q + CW'(1);
			end
		end
	end

	// cell memory, one read and one write port
	mgd_pkg::cell_t mem [2**AW];
	mgd_pkg::cell_t mem_q, wr_s5;
	logic [AW-1:0] req_addr, rd_addr;
	assign req_addr = {RW'(req_row), CW'(req_col)};
	assign rd_addr  = cmd.sweep_issue ? {rr_q, cc_q} : req_addr;

	always_ff @(posedge clk) begin
		mem_q <= mem[rd_addr];
		if (cmd.load_we) mem[req_addr] <= {req_wall, req_pressure};
		else if (v_s5) mem[{row_s5, col_s5}] <= wr_s5;
	end

	// line buffers with the two rows above, as they were before the sweep
	mgd_pkg::cell_t lb1 [MAX_COLS];
	mgd_pkg::cell_t lb2 [MAX_COLS];
	mgd_pkg::cell_t lb1_q, lb2_q;
	always_ff @(posedge clk) begin
		if (cmd.sweep_issue) begin
			lb1_q <= lb1[cc_q];
			lb2_q <= lb2[cc_q];
		end
		if (v_s1) begin
			lb1[cc_s1] <= mem_q;
			lb2[cc_s1] <= lb1_q;
		end
	end

	// column window: previous column full, the one before only the middle row
	mgd_pkg::cell_t up_q, mid_q, dn_q, left_q;
	always_ff @(posedge clk) begin
		if (v_s1) begin
			up_q   <= lb2_q;
			mid_q  <= lb1_q;
			dn_q   <= mem_q;
			left_q <= mid_q;
		end
	end

	// stage 1: neighbor select, wall neighbors take the centre value
	logic elig_s1;
	logic signed [17:0] n_s2 [4];
	logic signed [17:0] p_s2, p_s3, p_s4;
	logic wall_s2, wall_s3, wall_s4;
	assign elig_s1 = v_s1 && (rr_s1 > RW'(1)) && (cc_s1 > CW'(1));

	always_ff @(posedge clk) begin
		n_s2[0] <= up_q.wall   ? mid_q.pressure : up_q.pressure;
		n_s2[1] <= dn_q.wall   ? mid_q.pressure : dn_q.pressure;
		n_s2[2] <= left_q.wall ? mid_q.pressure : left_q.pressure;
		n_s2[3] <= lb1_q.wall  ? mid_q.pressure : lb1_q.pressure;
		p_s2    <= mid_q.pressure;
		wall_s2 <= mid_q.wall;
		row_s2  <= rr_s1 - RW'(1);
		col_s2  <= cc_s1 - CW'(1);
	end

	// stage 2: laplacian
	logic signed [mgd_pkg::LAP_W-1:0] lap_s3;
	always_ff @(posedge clk) begin
		lap_s3 <= mgd_pkg::LAP_W'(n_s2[0]) + mgd_pkg::LAP_W'(n_s2[1])
			+ mgd_pkg::LAP_W'(n_s2[2]) + mgd_pkg::LAP_W'(n_s2[3])
			- (mgd_pkg::LAP_W'(p_s2) <<< 2);
		p_s3    <= p_s2;
		wall_s3 <= wall_s2;
		row_s3  <= row_s2;
		col_s3  <= col_s2;
	end

	// stage 3: gain product
	logic signed [mgd_pkg::PROD_W-1:0] prod_s4;
	logic signed [16:0] gain_sx;
	assign gain_sx = {1'b0, gain_q};
	always_ff @(posedge clk) begin
		prod_s4 <= mgd_pkg::PROD_W'(gain_sx) * mgd_pkg::PROD_W'(lap_s3);
		p_s4    <= p_s3;
		wall_s4 <= wall_s3;
		row_s4  <= row_s3;
		col_s4  <= col_s3;
	end

	// stage 4: floor, add, saturate
	logic signed [mgd_pkg::NV_W-1:0] nv;
	logic sat_hi, sat_lo, sat_s5;
	always_comb begin
		nv     = mgd_pkg::NV_W'(p_s4) + mgd_pkg::NV_W'(prod_s4 >>> 16);
		sat_hi = nv > mgd_pkg::P_MAX;
		sat_lo = nv < mgd_pkg::P_MIN;
	end

	always_ff @(posedge clk) begin
		if (wall_s4) wr_s5 <= {1'b1, mgd_pkg::ONE_Q12};
		else if (sat_hi) wr_s5 <= {1'b0, mgd_pkg::P_MAX[17:0]};
		else if (sat_lo) wr_s5 <= {1'b0, mgd_pkg::P_MIN[17:0]};
		else wr_s5 <= {1'b0, nv[17:0]};
		sat_s5 <= !wall_s4 && (sat_hi || sat_lo);
		row_s5 <= row_s4;
		col_s5 <= col_s4;
	end

	// stage valids and sweep saturation flag
	logic sat_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			cc_s1 <= '0;
			rr_s1 <= '0;
			sat_q <= 1'b0;
		end else begin
			v_s1  <= cmd.sweep_issue;
			cc_s1 <= cc_q;
			rr_s1 <= rr_q;
			v_s2  <= elig_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			if (cmd.sweep_start) sat_q <= 1'b0;
			else if (v_s5 && sat_s5) sat_q <= 1'b1;
		end
	end

	// response registers
	always_ff @(posedge clk) begin
		if (cmd.rsp_ld) begin
			pressure_out <= '0;
			wall_out     <= 1'b0;
			status       <= 1'b0;
			saturated    <= 1'b0;
			unique case (cmd.rsp_src)
				mgd_pkg::RSP_RANGE: status <= 1'b1;
				mgd_pkg::RSP_READ: begin
					pressure_out <= mem_q.pressure;
					wall_out     <= mem_q.wall;
				end
				mgd_pkg::RSP_SWEEP: saturated <= sat_q;
				default: ;
			endcase
		end
	end

	`MGD_ASSERT(a_interior_wr, clk, arst_n, v_s5 |-> (row_s5 != '0 && col_s5 != '0), "sweep wrote a border cell")
	`MGD_ASSERT(a_pipe_chain, clk, arst_n, v_s3 |-> $past(v_s2), "stencil pipeline valid skipped")
	`MGD_NEVER(a_wr_clash, clk, arst_n, cmd.load_we && v_s5, "load collides with sweep write")

endmodule

/* sv/masked_grid_diffusion_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_grid_diffusion_step
// grid of pressure cells with wall flags, load / read / jacobi sweep
// ----------------------------------------------------------------------------
//  channel  dir  moves
//  req      in   action, col, row, pressure_in, wall_in
//  rsp      out  pressure_out, wall_out, status, saturated
//  cfg      in   index, data (cols, rows, gain)
//
//  load: writes the cell as the request is taken; read: through the registered cell memory read
//  sweep: one cell per cycle through the single memory read port
//  reset clears control and sets config to its defaults only, cells hold nothing until loaded
//  a finished response waits in its register; the next request is taken
//  once that response is taken, or in the same cycle
module masked_grid_diffusion_step #(
	parameter int MAX_COLS = mgd_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = mgd_pkg::DEF_MAX_ROWS
) (
	input logic      clk,
	input logic      arst_n,
	mgd_req_if.sink  req,
	mgd_rsp_if.source rsp,
	mgd_cfg_if.sink  cfg
);

	mgd_pkg::ctl_cmd_t    cmd;
	mgd_pkg::ctl_status_t sts;

	// config writes are always taken
	assign cfg.ready = 1'b1;

	mgd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	mgd_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.req_col      (req.col),
		.req_row      (req.row),
		.req_pressure (req.pressure_in),
		.req_wall     (req.wall_in),
		.cmd          (cmd),
		.sts          (sts),
		.pressure_out (rsp.pressure_out),
		.wall_out     (rsp.wall_out),
		.status       (rsp.status),
		.saturated    (rsp.saturated)
	);

endmodule
